### sv/line_substring_filter_defines.svh
`ifndef LINE_SUBSTRING_FILTER_DEFINES_SVH
`define LINE_SUBSTRING_FILTER_DEFINES_SVH

// condition holds at every edge out of reset
`define LSF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequence holds in the same cycle
`define LSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the next cycle
`define LSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lsf_pkg.sv
`default_nettype none

package lsf_pkg;

    localparam int LINE_LIMIT_DEF  = 126;
    localparam int PATTERN_MAX_DEF = 16;

    localparam int PLEN_W     = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int PAT_W      = 128;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int M_USED_W   = 35;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_EOS  = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_HIGH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAT_LEN  = 2'd2;

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_FETCH,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic       push;
        logic       clear;
        logic       len_ok;
        logic [7:0] data;
    } t_match_ctrl;

    typedef struct packed {
        logic       we;
        logic [1:0] lane;
        logic [7:0] data;
    } t_mem_wr;

endpackage

`default_nettype wire

### sv/lsf_line_mem.sv
`default_nettype none

module lsf_line_mem #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5
) (
    input  wire logic                 i_clk,
    input  wire lsf_pkg::t_mem_wr     i_wr,
    input  wire logic [ROW_W-1:0]     i_waddr,
    input  wire logic                 i_re,
    input  wire logic [ROW_W-1:0]     i_raddr,
    output logic      [31:0]          o_rdata
);

    logic [3:0][7:0] mem [ROWS];
    logic [31:0]     r_rdata;

    // byte-lane write, one 4-byte row read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_waddr][i_wr.lane] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/lsf_matcher.sv
`default_nettype none

module lsf_matcher #(
    parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lsf_pkg::t_match_ctrl         i_ctl,
    input  wire logic [lsf_pkg::PAT_W-1:0]    i_pattern,
    input  wire logic [lsf_pkg::PLEN_W-1:0]   i_plen,
    output logic                              o_match_seen
);

    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0] r_win [PATTERN_MAX];
    logic [7:0] nw    [PATTERN_MAX];
    logic       r_match_seen;
    logic       eq;

    // window after the new byte shifts in
    always_comb begin
        nw[0] = i_ctl.data;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            nw[j] = r_win[j-1];
        end
    end

    always_comb begin
        logic [lsf_pkg::PLEN_W-1:0] idx;
        eq  = 1'b1;
        idx = '0;
        for (int k = 0; k < PATTERN_MAX; k++) begin
            idx = i_plen - lsf_pkg::PLEN_W'(k) - lsf_pkg::PLEN_W'(1);
            if (lsf_pkg::PLEN_W'(k) < i_plen) begin
                if (nw[idx[IW-1:0]] != i_pattern[8*k +: 8]) begin
                    eq = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= '0;
            end
            r_match_seen <= 1'b0;
        end else if (i_ctl.clear) begin
            r_match_seen <= 1'b0;
        end else if (i_ctl.push) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win[j] <= nw[j];
            end
            if (i_ctl.len_ok && eq) begin
                r_match_seen <= 1'b1;
            end
        end
    end

    assign o_match_seen = r_match_seen;

endmodule

`default_nettype wire

### sv/line_substring_filter.sv
`default_nettype none

// Fixed-string line filter. Bytes come in on the slave stream one per cycle while
// tready is high and are held in a line memory of 4-byte rows; a line ends on LF,
// at end of stream or on a byte that arrives when LINE_LIMIT bytes are held, and
// CR is dropped. A line that contains the pattern goes out with CR LF appended, up
// to four bytes per output item, tlast on the final one. While a matching line is
// sent, input is stopped: each output item is one row read through the memory's
// single registered read port, then a load of the output register, which waits
// while the master stalls. Configure only while no line is being sent.
module line_substring_filter #(
    parameter int LINE_LIMIT  = lsf_pkg::LINE_LIMIT_DEF,
    parameter int PATTERN_MAX = lsf_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic [lsf_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [lsf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // slave stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [lsf_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,  // data_byte[7:0]
    input  wire logic                             i_s_axis_tuser,  // mode
    // master stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [lsf_pkg::M_TDATA_W-1:0]         o_m_axis_tdata,
    // byte_0[7:0], byte_1[15:8], byte_2[23:16], byte_3[31:24], byte_count[34:32], zeros
    output logic                                  o_m_axis_tlast
);

    `include "line_substring_filter_defines.svh"

    localparam int LW    = $clog2(LINE_LIMIT + 1);
    localparam int PW    = LW + 1;
    localparam int ROWS  = (LINE_LIMIT + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int GRP_W = $clog2(ROWS + 1);
    localparam int CW    = (LW > lsf_pkg::PLEN_W) ? LW : lsf_pkg::PLEN_W;

    lsf_pkg::t_state             r_state, n_state;
    logic [LW-1:0]               r_len, n_len;
    logic [GRP_W-1:0]            r_grp, n_grp;
    logic [lsf_pkg::CFG_DATA_W-1:0] r_pat_lo, r_pat_hi;
    logic [lsf_pkg::PLEN_W-1:0]  r_plen;
    logic [lsf_pkg::PLEN_W-1:0]  plen_eff;
    logic                        r_out_valid;
    logic [lsf_pkg::M_USED_W-1:0] r_out_data;
    logic                        r_out_last;

    lsf_pkg::t_match_ctrl        mctl;
    lsf_pkg::t_mem_wr            mwr;
    logic                        mem_re;
    logic [ROW_W-1:0]            mem_raddr;
    logic [31:0]                 mem_rdata;
    logic                        match_seen;

    logic                        s_acc;
    logic                        line_end;
    logic [LW-1:0]               len_next;
    logic                        out_load;

    logic [PW-1:0]               base, lenp, totp, rem;
    logic [3:0][7:0]             grp_bytes;
    logic [2:0]                  grp_cnt;
    logic                        grp_last;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_plen   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                lsf_pkg::CFG_PAT_LOW:  r_pat_lo <= i_cfg_wdata;
                lsf_pkg::CFG_PAT_HIGH: r_pat_hi <= i_cfg_wdata;
                lsf_pkg::CFG_PAT_LEN:  r_plen   <= i_cfg_wdata[lsf_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign plen_eff = (r_plen > lsf_pkg::PLEN_W'(PATTERN_MAX))
                    ? lsf_pkg::PLEN_W'(PATTERN_MAX) : r_plen;

    assign o_s_axis_tready = (r_state == lsf_pkg::ST_COLLECT);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign line_end        = (i_s_axis_tuser == lsf_pkg::MODE_EOS)
                          || (i_s_axis_tdata == lsf_pkg::CHAR_LF)
                          || (r_len >= LW'(LINE_LIMIT));
    assign len_next        = r_len + LW'(1);
    assign out_load        = (r_state == lsf_pkg::ST_LOAD)
                          && (!r_out_valid || i_m_axis_tready);

    // group assembly from the row just read
    always_comb begin
        logic [PW-1:0] p;
        base = PW'({r_grp, 2'b00});
        lenp = PW'(r_len);
        totp = lenp + PW'(2);
        rem  = totp - base;
        p    = '0;
        for (int k = 0; k < 4; k++) begin
            p = base + PW'(k);
            if (p < lenp) begin
                grp_bytes[k] = mem_rdata[8*k +: 8];
            end else if (p == lenp) begin
                grp_bytes[k] = lsf_pkg::CHAR_CR;
            end else if (p == lenp + PW'(1)) begin
                grp_bytes[k] = lsf_pkg::CHAR_LF;
            end else begin
                grp_bytes[k] = '0;
            end
        end
        grp_cnt  = (rem >= PW'(4)) ? 3'd4 : rem[2:0];
        grp_last = (base + PW'(4)) >= totp;
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_grp   = r_grp;
        mctl    = '0;
        mwr     = '0;
        mem_re  = 1'b0;
        mctl.data   = i_s_axis_tdata;
        mctl.len_ok = CW'(len_next) >= CW'(plen_eff);
        mwr.data    = i_s_axis_tdata;
        mwr.lane    = r_len[1:0];
        case (r_state)
            lsf_pkg::ST_COLLECT: begin
                if (s_acc) begin
                    if (line_end) begin
                        if (match_seen && (r_len != '0)) begin
                            n_grp   = '0;
                            n_state = lsf_pkg::ST_FETCH;
                        end else begin
                            n_len      = '0;
                            mctl.clear = 1'b1;
                        end
                    end else if (i_s_axis_tdata != lsf_pkg::CHAR_CR) begin
                        mwr.we    = 1'b1;
                        mctl.push = 1'b1;
                        n_len     = len_next;
                    end
                end
            end
            lsf_pkg::ST_FETCH: begin
                mem_re  = 1'b1;
                n_state = lsf_pkg::ST_LOAD;
            end
            lsf_pkg::ST_LOAD: begin
                if (out_load) begin
                    n_grp = r_grp + GRP_W'(1);
                    if (grp_last) begin
                        n_state    = lsf_pkg::ST_COLLECT;
                        n_len      = '0;
                        mctl.clear = 1'b1;
                    end else begin
                        n_state = lsf_pkg::ST_FETCH;
                    end
                end
            end
            default: n_state = lsf_pkg::ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsf_pkg::ST_COLLECT;
            r_len   <= '0;
            r_grp   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_grp   <= n_grp;
        end
    end

    assign mem_raddr = (r_grp < GRP_W'(ROWS)) ? r_grp[ROW_W-1:0] : '0;

    lsf_line_mem #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_wr    (mwr),
        .i_waddr (ROW_W'(r_len >> 2)),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    lsf_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mctl),
        .i_pattern    ({r_pat_hi, r_pat_lo}),
        .i_plen       (plen_eff),
        .o_match_seen (match_seen)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {grp_cnt, grp_bytes};
            r_out_last <= grp_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = lsf_pkg::M_TDATA_W'(r_out_data);
    assign o_m_axis_tlast  = r_out_last;

    `LSF_ASSERT_ALWAYS(a_len_bound, r_len <= LW'(LINE_LIMIT), "line length beyond limit")
    `LSF_ASSERT_NOW(a_match_nonempty, match_seen, r_len != '0, "match flagged on empty line")
    `LSF_ASSERT_NEXT(a_last_returns, out_load && grp_last,
        (r_state == lsf_pkg::ST_COLLECT) && (r_len == '0) && !match_seen,
        "line state not cleared after last group")
    `LSF_ASSERT_NOW(a_count_range, r_out_valid,
        (r_out_data[34:32] != 3'd0) && (r_out_data[34:32] <= 3'd4),
        "output byte count out of range")

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;

    localparam int CLK_HALF   = 6;
    localparam int RESET_CYC  = 12;
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_CYC  = 10;
    localparam int STALL_LEN  = 250;
    localparam int PRINT_CAP  = 20;
    localparam logic [lsf_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } t_stream_item;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
        logic            last;
    } t_out_group;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [lsf_pkg::CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [lsf_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic [lsf_pkg::S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                           i_s_axis_tuser = 1'b0;
    logic                           i_m_axis_tready = 1'b0;
    logic                           o_s_axis_tready;
    logic                           o_m_axis_tvalid;
    logic [lsf_pkg::M_TDATA_W-1:0]  o_m_axis_tdata;
    logic                           o_m_axis_tlast;

    line_substring_filter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // filter state mirrored by the predictor
    logic [63:0]                pat_lo = '0;
    logic [63:0]                pat_hi = '0;
    logic [lsf_pkg::PLEN_W-1:0] pat_len = '0;
    logic [7:0]                 held_line [lsf_pkg::LINE_LIMIT_DEF];
    int                         held_len = 0;
    logic [7:0]                 recent [lsf_pkg::PATTERN_MAX_DEF];
    bit                         line_hit = 1'b0;

    t_stream_item pending_bytes[$];
    t_out_group   expected_groups[$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_stall_go = 1'b0;
    int  rx_stall_cnt = 0;
    int  mismatches = 0;
    int  items_sent = 0;
    int  items_queued = 0;
    int  groups_checked = 0;
    int  lines_emitted = 0;
    int  settings_used = 0;
    int  cycles = 0;

    function automatic int eff_pattern_len();
        return (pat_len > lsf_pkg::PATTERN_MAX_DEF) ? lsf_pkg::PATTERN_MAX_DEF : int'(pat_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int k);
        logic [127:0] pat;
        pat = {pat_hi, pat_lo};
        return pat[8*k +: 8];
    endfunction

    function automatic void queue_line_groups();
        int         total;
        int         p;
        t_out_group g;
        total = held_len + 2;
        p = 0;
        while (p < total) begin
            g = '0;
            for (int k = 0; k < 4; k++) begin
                if (p < total) begin
                    if (p < held_len)
                        g.bytes[k] = held_line[p];
                    else if (p == held_len)
                        g.bytes[k] = lsf_pkg::CHAR_CR;
                    else
                        g.bytes[k] = lsf_pkg::CHAR_LF;
                    p++;
                    g.count++;
                end
            end
            g.last = (p >= total);
            expected_groups.push_back(g);
        end
    endfunction

    function automatic void predict_filter_step(input logic mode, input logic [7:0] c);
        int plen;
        bit eq;
        if (mode == lsf_pkg::MODE_EOS) begin
            if (held_len > 0 && line_hit)
                queue_line_groups();
            held_len = 0;
            line_hit = 1'b0;
            return;
        end
        if (c == lsf_pkg::CHAR_LF || held_len >= lsf_pkg::LINE_LIMIT_DEF) begin
            if (line_hit)
                queue_line_groups();
            held_len = 0;
            line_hit = 1'b0;
            return;
        end
        if (c != lsf_pkg::CHAR_CR) begin
            held_line[held_len] = c;
            held_len++;
            for (int k = lsf_pkg::PATTERN_MAX_DEF - 1; k > 0; k--)
                recent[k] = recent[k-1];
            recent[0] = c;
            plen = eff_pattern_len();
            if (held_len >= plen) begin
                eq = 1'b1;
                for (int k = 0; k < plen; k++)
                    if (recent[plen-1-k] != pattern_byte(k))
                        eq = 1'b0;
                if (eq)
                    line_hit = 1'b1;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("mismatch on %s: got %0h, want %0h (output item %0d)",
                     what, got, want, groups_checked);
        mismatches++;
    endtask

    // driver
    t_stream_item tx_item;
    bit           tx_fire;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            tx_fire = i_s_axis_tvalid && o_s_axis_tready;
            if (tx_fire) begin
                tx_item = pending_bytes.pop_front();
                predict_filter_step(tx_item.mode, tx_item.data);
                items_sent++;
            end
            if (!i_s_axis_tvalid || tx_fire) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pending_bytes[0].data;
                    i_s_axis_tuser  <= pending_bytes[0].mode;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!rx_stall_go)
            rx_stall_cnt <= 0;
        else if (rx_stall_cnt < STALL_LEN)
            rx_stall_cnt <= rx_stall_cnt + 1;
    end

    // monitor
    t_out_group want_group;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_groups.size() == 0) begin
                    report_mismatch("unexpected item", 64'(o_m_axis_tdata), '0);
                end else begin
                    want_group = expected_groups.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (o_m_axis_tdata[8*k +: 8] !== want_group.bytes[k])
                            report_mismatch($sformatf("byte_%0d", k),
                                            64'(o_m_axis_tdata[8*k +: 8]),
                                            64'(want_group.bytes[k]));
                    if (o_m_axis_tdata[34:32] !== want_group.count)
                        report_mismatch("byte_count", 64'(o_m_axis_tdata[34:32]),
                                        64'(want_group.count));
                    if (o_m_axis_tdata[lsf_pkg::M_TDATA_W-1:lsf_pkg::M_USED_W] !== '0)
                        report_mismatch("tdata padding",
                            64'(o_m_axis_tdata[lsf_pkg::M_TDATA_W-1:lsf_pkg::M_USED_W]), '0);
                    if (o_m_axis_tlast !== want_group.last)
                        report_mismatch("last", 64'(o_m_axis_tlast), 64'(want_group.last));
                    if (want_group.last)
                        lines_emitted++;
                end
                groups_checked++;
            end
            i_m_axis_tready <= !(rx_stall_go && rx_stall_cnt < STALL_LEN)
                               && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_groups.size());
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic push_item(input logic mode, input logic [7:0] d);
        t_stream_item it;
        it.mode = mode;
        it.data = d;
        pending_bytes.push_back(it);
        items_queued++;
    endtask

    task automatic write_reg(input logic [lsf_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == lsf_pkg::CFG_PAT_LOW)
            pat_lo = val;
        else if (idx == lsf_pkg::CFG_PAT_HIGH)
            pat_hi = val;
        else if (idx == lsf_pkg::CFG_PAT_LEN)
            pat_len = val[lsf_pkg::PLEN_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_s_axis_tvalid || expected_groups.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == lsf_pkg::CHAR_LF || b == lsf_pkg::CHAR_CR)
            b = 8'h20;
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return (eff_pattern_len() > 0)
                ? pattern_byte(int'($urandom_range(eff_pattern_len() - 1)))
                : 8'($urandom_range(8'h61, 8'h63));
        if (r < 75)
            return lsf_pkg::CHAR_CR;
        return 8'($urandom_range(255));
    endfunction

    // line that runs into the limit, pattern placed at its very end
    task automatic push_limit_line();
        int plen;
        plen = eff_pattern_len();
        for (int k = 0; k < lsf_pkg::LINE_LIMIT_DEF; k++) begin
            if (plen > 0 && k >= lsf_pkg::LINE_LIMIT_DEF - plen)
                push_item(lsf_pkg::MODE_BYTE,
                          pattern_byte(k - (lsf_pkg::LINE_LIMIT_DEF - plen)));
            else
                push_item(lsf_pkg::MODE_BYTE, plain_byte());
        end
        push_item(lsf_pkg::MODE_BYTE, plain_byte());
        push_item(lsf_pkg::MODE_BYTE, plain_byte());
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
    endtask

    task automatic queue_random_stream(input int n_items);
        int         start;
        int         r;
        int         len;
        int         at;
        int         plen;
        logic [7:0] line_q[$];
        start = items_queued;
        plen = eff_pattern_len();
        while (items_queued - start < n_items) begin
            r = $urandom_range(99);
            if (r < 75) begin
                line_q.delete();
                len = $urandom_range(0, 10);
                for (int k = 0; k < len; k++)
                    line_q.push_back(pick_byte());
                if (plen > 0 && $urandom_range(99) < 60) begin
                    at = $urandom_range(0, line_q.size());
                    for (int k = plen - 1; k >= 0; k--)
                        line_q.insert(at, pattern_byte(k));
                end
                foreach (line_q[j])
                    push_item(lsf_pkg::MODE_BYTE, line_q[j]);
                if ($urandom_range(9) == 0)
                    push_item(lsf_pkg::MODE_EOS, 8'($urandom_range(255)));
                else
                    push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
            end else if (r < 90) begin
                // pattern cut short or with its final byte changed
                for (int k = 0; k + 1 < plen; k++)
                    push_item(lsf_pkg::MODE_BYTE, pattern_byte(k));
                if (plen > 0 && $urandom_range(1) == 1)
                    push_item(lsf_pkg::MODE_BYTE, pattern_byte(plen - 1) ^ 8'h01);
                push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    push_item(($urandom_range(3) == 0) ? lsf_pkg::MODE_EOS : lsf_pkg::MODE_BYTE,
                              8'($urandom_range(255)));
            end
        end
        push_item(lsf_pkg::MODE_EOS, 8'($urandom_range(255)));
    endtask

    initial begin : stimulus
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct <= 32;
        rx_idle_pct <= 83;

        // empty pattern from reset: every non-empty line goes out
        settings_used++;
        push_item(lsf_pkg::MODE_EOS, 8'hFF);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_CR);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
        push_item(lsf_pkg::MODE_BYTE, 8'h00);
        push_item(lsf_pkg::MODE_BYTE, 8'hFF);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
        push_item(lsf_pkg::MODE_BYTE, 8'h41);
        push_item(lsf_pkg::MODE_EOS, 8'h00);
        push_item(lsf_pkg::MODE_EOS, 8'h5A);
        wait_drained();

        // two-byte pattern, junk in unused bytes and at the unused index
        settings_used++;
        write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(lsf_pkg::CFG_PAT_LOW, 64'hDEAD_BEEF_0000_6261);
        write_reg(lsf_pkg::CFG_PAT_HIGH, 64'h0123_4567_89AB_CDEF);
        write_reg(lsf_pkg::CFG_PAT_LEN, 64'hFFFF_FFFF_FFFF_FFE2);
        push_item(lsf_pkg::MODE_BYTE, 8'h61);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_CR);
        push_item(lsf_pkg::MODE_BYTE, 8'h62);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
        push_item(lsf_pkg::MODE_BYTE, 8'h61);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
        push_item(lsf_pkg::MODE_BYTE, 8'h78);
        push_item(lsf_pkg::MODE_BYTE, 8'h61);
        push_item(lsf_pkg::MODE_BYTE, 8'h62);
        push_item(lsf_pkg::MODE_BYTE, 8'h79);
        push_item(lsf_pkg::MODE_BYTE, 8'h7A);
        push_item(lsf_pkg::MODE_BYTE, lsf_pkg::CHAR_LF);
        wait_drained();

        // one-byte random pattern
        settings_used++;
        write_reg(lsf_pkg::CFG_PAT_LOW, {$urandom(), $urandom()});
        write_reg(lsf_pkg::CFG_PAT_HIGH, {$urandom(), $urandom()});
        write_reg(lsf_pkg::CFG_PAT_LEN, 64'd1);
        queue_random_stream(12);
        wait_drained();

        // all-ones pattern, length above the maximum, longest line
        settings_used++;
        write_reg(lsf_pkg::CFG_PAT_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(lsf_pkg::CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(lsf_pkg::CFG_PAT_LEN, 64'd31);
        push_limit_line();
        queue_random_stream(6);
        wait_drained();

        tx_idle_pct <= 83;
        rx_idle_pct <= 32;
        settings_used++;
        write_reg(lsf_pkg::CFG_PAT_LOW, {$urandom(), $urandom()});
        write_reg(lsf_pkg::CFG_PAT_HIGH, {$urandom(), $urandom()});
        write_reg(lsf_pkg::CFG_PAT_LEN,
                  ({$urandom(), $urandom()} & ~64'h1F) | 64'($urandom_range(2, 16)));
        queue_random_stream(6);
        // sender waits for every result before going on
        while (pending_bytes.size() != 0 || i_s_axis_tvalid || expected_groups.size() != 0)
            @(posedge i_clk);
        queue_random_stream(6);
        wait_drained();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        settings_used++;
        write_reg(lsf_pkg::CFG_PAT_LOW, 64'd0);
        write_reg(lsf_pkg::CFG_PAT_HIGH, 64'd0);
        write_reg(lsf_pkg::CFG_PAT_LEN, 64'd0);
        queue_random_stream(20);
        @(posedge i_clk);
        rx_stall_go <= 1'b1;
        @(posedge i_clk);
        while (rx_stall_cnt < STALL_LEN)
            @(posedge i_clk);
        rx_stall_go <= 1'b0;
        wait_drained();

        $display("sent %0d stream items under %0d pattern settings, idle and stall mixes",
                 items_sent, settings_used);
        $display("checked %0d output items forming %0d emitted lines",
                 groups_checked, lines_emitted);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
